// ===== hdl/kpsd_pkg.sv =====
package kpsd_pkg;

  // field widths
  localparam int unsigned OPCODE_W   = 1;
  localparam int unsigned COLUMN_W   = 4;
  localparam int unsigned ROW_W      = 4;
  localparam int unsigned KEY_W      = 4;
  localparam int unsigned HOLDOFF_W  = 16;
  localparam int unsigned ROW_SEL_W  = 2;
  localparam int unsigned LAST_KEY_W = KEY_W + 1;

  // reset values and defaults
  localparam int unsigned FIFO_DEPTH_DEF = 16;
  localparam logic [HOLDOFF_W-1:0]  HOLDOFF_RESET = 16'd40;
  localparam logic [ROW_W-1:0]      DRIVE_RESET   = 4'hF;
  localparam logic [LAST_KEY_W-1:0] NO_KEY        = 5'h10;

  // word operations
  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  // column sample codes that stand for a single pressed key
  localparam logic [COLUMN_W-1:0] COL0_LOW = 4'hE;
  localparam logic [COLUMN_W-1:0] COL1_LOW = 4'hD;
  localparam logic [COLUMN_W-1:0] COL2_LOW = 4'hB;
  localparam logic [COLUMN_W-1:0] COL3_LOW = 4'h7;

  // result word as held in the output register
  typedef struct packed {
    logic [ROW_W-1:0] row_drive;
    logic             key_valid;
    logic [KEY_W-1:0] key_code;
    logic             overflow;
  } out_word_t;

  // one-low column sample to {pressed, column}
  function automatic logic [2:0] decode_columns(input logic [COLUMN_W-1:0] cols);
    logic [2:0] res;
    unique case (cols)
      COL0_LOW: res = 3'b100;
      COL1_LOW: res = 3'b101;
      COL2_LOW: res = 3'b110;
      COL3_LOW: res = 3'b111;
      default:  res = 3'b000;
    endcase
    return res;
  endfunction

  // active-low drive for one row
  function automatic logic [ROW_W-1:0] row_pattern(input logic [ROW_SEL_W-1:0] row);
    logic [ROW_W-1:0] pat;
    pat = ~(ROW_W'(1) << row);
    return pat;
  endfunction

endpackage

// ===== hdl/kpsd_if.sv =====
// input channel: operation and column sample
interface kpsd_in_if import kpsd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [COLUMN_W-1:0] column_lines;

  modport source (output valid, opcode, column_lines, input ready);
  modport sink   (input valid, opcode, column_lines, output ready);
endinterface

// result channel: row drive, popped key and overflow flag
interface kpsd_out_if import kpsd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_drive;
  logic             key_valid;
  logic [KEY_W-1:0] key_code;
  logic             overflow;

  modport source (output valid, row_drive, key_valid, key_code, overflow, input ready);
  modport sink   (input valid, row_drive, key_valid, key_code, overflow, output ready);
endinterface

// ===== hdl/kpsd_ram.sv =====
module kpsd_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read that holds without a read enable
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/keypad_scan_debounce_fifo_core.sv =====
// channel   dir  handshake              payload
// in_ch     in   valid/ready            opcode, column_lines
// out_ch    out  valid/ready            row_drive, key_valid, key_code, overflow
// cfg       in   cfg_we (no back-press) cfg_wdata = holdoff_ticks
//
// one word per cycle unless out_ch stalls with both registers full; each result
// passes the stage register, beside the memory's registered read, then out_r
// scan state, pointers and count update in the accept cycle; pops read the memory
// a stage register and the output register decouple the two sides, so one
// more word is taken while a result waits
// rst_n is synchronous; the key memory needs no clearing
module keypad_scan_debounce_fifo_core import kpsd_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  kpsd_in_if.sink              in_ch,
  kpsd_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [HOLDOFF_W-1:0] cfg_wdata
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  // configuration and scan state
  logic [HOLDOFF_W-1:0]  holdoff_ticks_r;
  logic [HOLDOFF_W-1:0]  holdoff_cnt_r, holdoff_cnt_nxt;
  logic [ROW_SEL_W-1:0]  scan_row_r, scan_row_nxt;
  logic [LAST_KEY_W-1:0] last_key_r [4];
  logic [LAST_KEY_W-1:0] last_key_nxt [4];
  logic [ROW_W-1:0]      drive_r, drive_nxt;

  // queue pointers and fill
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // pipeline
  logic             s1_valid_r;
  logic [ROW_W-1:0] s1_drive_r, s1_drive_nxt;
  logic             s1_kv_r, s1_kv_nxt;
  logic             s1_ovf_r, s1_ovf_nxt;
  logic             out_valid_r;
  out_word_t        out_r;
  out_word_t        s1_word;

  logic             in_acc;
  logic             s1_adv;
  logic             ram_we, ram_re;
  logic [KEY_W-1:0] ram_wdata, ram_rdata;
  logic [2:0]       col_dec;
  logic [LAST_KEY_W-1:0] key_now;
  op_t              op;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign op          = op_t'(in_ch.opcode);

  // decode the sample of the row under scan
  assign col_dec = decode_columns(in_ch.column_lines);
  assign key_now = col_dec[2] ? {1'b0, scan_row_r, col_dec[1:0]} : NO_KEY;
  assign ram_wdata = key_now[KEY_W-1:0];

  // per-word state update
  always_comb begin
    holdoff_cnt_nxt = holdoff_cnt_r;
    scan_row_nxt    = scan_row_r;
    last_key_nxt    = last_key_r;
    drive_nxt       = drive_r;
    wr_ptr_nxt      = wr_ptr_r;
    rd_ptr_nxt      = rd_ptr_r;
    count_nxt       = count_r;
    s1_kv_nxt       = 1'b0;
    s1_ovf_nxt      = 1'b0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    if (in_acc) begin
      unique case (op)
        OP_POP: begin
          if (count_r != '0) begin
            ram_re     = 1'b1;
            s1_kv_nxt  = 1'b1;
            rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
            count_nxt  = count_r - 1'b1;
          end
        end
        OP_TICK: begin
          if (holdoff_cnt_r != '0) begin
            holdoff_cnt_nxt = holdoff_cnt_r - 1'b1;
          end else begin
            if (key_now != last_key_r[scan_row_r]) begin
              last_key_nxt[scan_row_r] = key_now;
              holdoff_cnt_nxt          = holdoff_ticks_r;
              if (key_now != NO_KEY) begin
                if (count_r == CNT_FULL) begin
                  s1_ovf_nxt = 1'b1;
                end else begin
                  ram_we     = 1'b1;
                  wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
                  count_nxt  = count_r + 1'b1;
                end
              end
            end
            scan_row_nxt = scan_row_r + 1'b1;
            drive_nxt    = row_pattern(scan_row_r + 1'b1);
          end
        end
        default: ;
      endcase
    end
    s1_drive_nxt = drive_nxt;
  end

  // key memory
  kpsd_ram #(
    .WIDTH (KEY_W),
    .DEPTH (FIFO_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holdoff_ticks_r <= HOLDOFF_RESET;
    end else if (cfg_we) begin
      holdoff_ticks_r <= cfg_wdata;
    end
  end

  // scan and queue state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holdoff_cnt_r <= '0;
      scan_row_r    <= '0;
      drive_r       <= DRIVE_RESET;
      wr_ptr_r      <= '0;
      rd_ptr_r      <= '0;
      count_r       <= '0;
      for (int i = 0; i < 4; i++) begin
        last_key_r[i] <= NO_KEY;
      end
    end else begin
      holdoff_cnt_r <= holdoff_cnt_nxt;
      scan_row_r    <= scan_row_nxt;
      drive_r       <= drive_nxt;
      wr_ptr_r      <= wr_ptr_nxt;
      rd_ptr_r      <= rd_ptr_nxt;
      count_r       <= count_nxt;
      last_key_r    <= last_key_nxt;
    end
  end

  // stage one: waits for the memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_drive_r <= s1_drive_nxt;
      s1_kv_r    <= s1_kv_nxt;
      s1_ovf_r   <= s1_ovf_nxt;
    end
  end

  // assemble the result word
  always_comb begin
    s1_word.row_drive = s1_drive_r;
    s1_word.key_valid = s1_kv_r;
    s1_word.key_code  = s1_kv_r ? ram_rdata : '0;
    s1_word.overflow  = s1_ovf_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= s1_word;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.row_drive = out_r.row_drive;
  assign out_ch.key_valid = out_r.key_valid;
  assign out_ch.key_code  = out_r.key_code;
  assign out_ch.overflow  = out_r.overflow;

  // fill never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("key queue fill beyond depth");

  // a push and a pop never meet in one cycle
  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("memory written and read together");

  // an overflow is only flagged against a full queue
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && s1_ovf_nxt) |-> (count_r == CNT_FULL))
    else $error("overflow with room in queue");

  // a pop that finds keys yields a valid key in stage one
  a_pop_key: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && op == OP_POP && count_r != '0) |=> (s1_valid_r && s1_kv_r))
    else $error("pop lost its key");

  // drive is all high or has exactly one low row
  a_drive_shape: assert property (@(posedge clk) disable iff (!rst_n)
    ($onehot(~drive_r) || drive_r == DRIVE_RESET))
    else $error("bad row drive pattern");

endmodule
